// ===== hdl/cli_pkg.sv =====
package cli_pkg;

    localparam int VAL_W  = 32;          // knot and result width, Q16.16
    localparam int DIFF_W = VAL_W + 1;   // exact difference of two values
    localparam int PROD_W = 2 * DIFF_W;  // magnitude product
    localparam int QBITS  = 41;          // quotient bits kept, covers 2^40 bound
    localparam int DSH_W  = PROD_W + 8;  // shifted divisor for restoring divide
    localparam int SUM_W  = 43;          // y0 plus or minus quotient

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    typedef enum logic [18:0] {
        S_IDLE = 19'b000_0000_0000_0000_0001,
        S_X0   = 19'b000_0000_0000_0000_0010,
        S_X1   = 19'b000_0000_0000_0000_0100,
        S_XL   = 19'b000_0000_0000_0000_1000,
        S_DIR  = 19'b000_0000_0000_0001_0000,
        S_SRD  = 19'b000_0000_0000_0010_0000,
        S_SCMP = 19'b000_0000_0000_0100_0000,
        S_F0   = 19'b000_0000_0000_1000_0000,
        S_F1   = 19'b000_0000_0001_0000_0000,
        S_F2   = 19'b000_0000_0010_0000_0000,
        S_CHK  = 19'b000_0000_0100_0000_0000,
        S_MUL0 = 19'b000_0000_1000_0000_0000,
        S_MUL1 = 19'b000_0001_0000_0000_0000,
        S_MUL2 = 19'b000_0010_0000_0000_0000,
        S_DIVI = 19'b000_0100_0000_0000_0000,
        S_DIV  = 19'b000_1000_0000_0000_0000,
        S_SUM  = 19'b001_0000_0000_0000_0000,
        S_FIN  = 19'b010_0000_0000_0000_0000,
        S_SPARE = 19'b100_0000_0000_0000_0000
    } t_state;

    typedef struct packed {
        logic wr;        // write knot from input item
        logic take;      // latch sample and clip
        logic ld_x0;
        logic ld_x1;
        logic shift_a;
        logic ld_seg0;
        logic ld_seg1;
        logic mul0;
        logic mul1;
        logic mul2;
        logic div_init;
        logic div_step;
        logic sum;
        logic fin;
        logic found;
    } t_cmd;

    typedef struct packed {
        logic flat;
        logic ext_lo;
        logic ext_hi;
        logic bracket;
        logic den_zero;
        logic ovf;
        logic out_free;
    } t_sts;

endpackage

// ===== hdl/cli_ram.sv =====
module cli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/cli_ctrl.sv =====
module cli_ctrl #(
    parameter int MAX_KNOTS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_action,
    input  logic [3:0]                   i_knot_index,
    input  logic                         i_cfg_we,
    input  logic [4:0]                   i_cfg_data,
    input  cli_pkg::t_sts                i_sts,
    output cli_pkg::t_cmd                o_cmd,
    output logic [$clog2(MAX_KNOTS)-1:0] o_waddr,
    output logic [$clog2(MAX_KNOTS)-1:0] o_raddr
);
    import cli_pkg::*;

    localparam int ADDR_W = $clog2(MAX_KNOTS);
    localparam int CNT_W  = $clog2(QBITS);

    t_state            r_state, n_state;
    logic [4:0]        r_len;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic [ADDR_W-1:0] r_hi, n_hi;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_hit, n_hit;
    logic [ADDR_W-1:0] w_last;
    logic              w_acc;

    assign w_acc      = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign o_waddr    = ADDR_W'(i_knot_index);

    // clamp the configured length to the table
    always_comb begin
        if (r_len < 5'd2) begin
            w_last = ADDR_W'(1);
        end else if (32'(r_len) > MAX_KNOTS) begin
            w_last = ADDR_W'(MAX_KNOTS - 1);
        end else begin
            w_last = ADDR_W'(r_len - 5'd1);
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_hi    = r_hi;
        n_cnt   = r_cnt;
        n_hit   = r_hit;
        o_cmd   = '0;
        o_raddr = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (i_action == ACT_LOAD) begin
                        o_cmd.wr = (32'(i_knot_index) < MAX_KNOTS);
                    end else begin
                        o_cmd.take = 1'b1;
                        n_state    = S_X0;
                    end
                end
            end
            S_X0: begin
                o_raddr = '0;
                n_state = S_X1;
            end
            S_X1: begin
                o_cmd.ld_x0 = 1'b1;
                o_raddr     = ADDR_W'(1);
                n_state     = S_XL;
            end
            S_XL: begin
                o_cmd.ld_x1 = 1'b1;
                o_raddr     = w_last;
                n_state     = S_DIR;
            end
            S_DIR: begin
                if (i_sts.flat) begin
                    n_hit   = 1'b0;
                    n_state = S_FIN;
                end else if (i_sts.ext_lo) begin
                    n_hi    = ADDR_W'(1);
                    n_state = S_F0;
                end else if (i_sts.ext_hi) begin
                    n_hi    = w_last;
                    n_state = S_F0;
                end else begin
                    n_idx   = ADDR_W'(1);
                    n_state = S_SRD;
                end
            end
            S_SRD: begin
                o_raddr = r_idx;
                n_state = S_SCMP;
            end
            S_SCMP: begin
                if (i_sts.bracket) begin
                    n_hi    = r_idx;
                    n_state = S_F0;
                end else if (r_idx == w_last) begin
                    n_hit   = 1'b0;
                    n_state = S_FIN;
                end else begin
                    o_cmd.shift_a = 1'b1;
                    n_idx         = r_idx + ADDR_W'(1);
                    n_state       = S_SRD;
                end
            end
            S_F0: begin
                o_raddr = r_hi - ADDR_W'(1);
                n_hit   = 1'b1;
                n_state = S_F1;
            end
            S_F1: begin
                o_cmd.ld_seg0 = 1'b1;
                o_raddr       = r_hi;
                n_state       = S_F2;
            end
            S_F2: begin
                o_cmd.ld_seg1 = 1'b1;
                n_state       = S_CHK;
            end
            S_CHK: begin
                n_state = i_sts.den_zero ? S_SUM : S_MUL0;
            end
            S_MUL0: begin
                o_cmd.mul0 = 1'b1;
                n_state    = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_DIVI;
            end
            S_DIVI: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                if (i_sts.ovf) begin
                    n_state = S_SUM;
                end else begin
                    o_cmd.div_step = 1'b1;
                    n_cnt          = r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(QBITS - 1)) begin
                        n_state = S_SUM;
                    end
                end
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                // hold until the output register is free
                if (i_sts.out_free) begin
                    o_cmd.fin   = 1'b1;
                    o_cmd.found = r_hit;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= 5'd2;
            r_idx   <= '0;
            r_hi    <= '0;
            r_cnt   <= '0;
            r_hit   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_hi    <= n_hi;
            r_cnt   <= n_cnt;
            r_hit   <= n_hit;
            if (i_cfg_we) begin
                r_len <= i_cfg_data;
            end
        end
    end

    a_fin_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fin |-> i_sts.out_free)
        else $error("result written while output register busy");

    a_seg_hi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_F0) |-> (r_hi != '0) && (r_hi <= w_last))
        else $error("segment index outside curve");

    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (32'(r_cnt) < QBITS))
        else $error("divide ran past its quotient width");

    a_scan_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCMP) |=> (r_state == S_SRD) || (r_state == S_F0) ||
                                (r_state == S_FIN))
        else $error("scan left to an unexpected state");

endmodule

// ===== hdl/cli_dp.sv =====
module cli_dp #(
    parameter int MAX_KNOTS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  cli_pkg::t_cmd                i_cmd,
    output cli_pkg::t_sts                o_sts,
    input  logic [$clog2(MAX_KNOTS)-1:0] i_waddr,
    input  logic [$clog2(MAX_KNOTS)-1:0] i_raddr,
    input  logic signed [31:0]           i_knot_in,
    input  logic signed [31:0]           i_knot_out,
    input  logic signed [31:0]           i_sample,
    input  logic                         i_clip,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [31:0]           o_value,
    output logic                         o_found
);
    import cli_pkg::*;

    localparam logic signed [VAL_W-1:0] V_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] V_MIN   = 32'sh8000_0000;
    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(V_MAX);
    localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(V_MIN);

    logic signed [VAL_W-1:0] w_rx, w_ry;
    logic signed [VAL_W-1:0] r_s, r_x0, r_x1, r_a, r_sx0, r_y0, r_y1;
    logic                    r_clip;
    logic [DIFF_W-1:0]       r_mdx, r_mdy, r_mden;
    logic                    r_neg, r_den_zero, r_ovf, r_big;
    logic [PROD_W-1:0]       r_prod, r_rem;
    logic [49:0]             r_pp;
    logic [DSH_W-1:0]        r_dsh;
    logic [QBITS-1:0]        r_q;
    logic signed [SUM_W-1:0] r_sum;
    logic                    r_out_valid, r_found;
    logic signed [VAL_W-1:0] r_value;

    logic signed [DIFF_W-1:0] w_dx, w_dy, w_den;
    logic [48:0]              w_p0;
    logic [49:0]              w_p1;
    logic                     w_pos, w_ge, w_qbig;
    logic signed [SUM_W-1:0]  w_y0e;
    logic [SUM_W-1:0]         w_qe;
    logic signed [VAL_W-1:0]  w_sat, w_clp, w_lo, w_up;

    cli_ram #(.WIDTH(VAL_W), .DEPTH(MAX_KNOTS)) u_ram_x (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr),
        .i_waddr (i_waddr),
        .i_wdata (i_knot_in),
        .i_raddr (i_raddr),
        .o_rdata (w_rx)
    );

    cli_ram #(.WIDTH(VAL_W), .DEPTH(MAX_KNOTS)) u_ram_y (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr),
        .i_waddr (i_waddr),
        .i_wdata (i_knot_out),
        .i_raddr (i_raddr),
        .o_rdata (w_ry)
    );

    assign w_pos = (r_x1 > r_x0);
    assign w_dx  = DIFF_W'(r_s) - DIFF_W'(r_sx0);
    assign w_dy  = DIFF_W'(w_ry) - DIFF_W'(r_y0);
    assign w_den = DIFF_W'(w_rx) - DIFF_W'(r_sx0);
    assign w_p0  = r_mdx[15:0] * r_mdy;
    assign w_p1  = r_mdx[32:16] * r_mdy;
    assign w_ge  = ({8'b0, r_rem} >= r_dsh);
    assign w_qbig = r_ovf || (r_q[QBITS-1] && (r_q[QBITS-2:0] != '0));
    assign w_y0e = SUM_W'(r_y0);
    assign w_qe  = SUM_W'(r_q);

    assign o_sts.flat     = (r_x1 == r_x0);
    assign o_sts.ext_lo   = w_pos ? (r_s < r_x0) : (r_s > r_x0);
    assign o_sts.ext_hi   = w_pos ? (r_s > w_rx) : (r_s < w_rx);
    assign o_sts.bracket  = w_pos ? (r_s <= w_rx && r_s >= r_a)
                                  : (r_s >= w_rx && r_s <= r_a);
    assign o_sts.den_zero = r_den_zero;
    assign o_sts.ovf      = r_ovf;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    function automatic logic [DIFF_W-1:0] f_mag(input logic signed [DIFF_W-1:0] v);
        f_mag = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
    endfunction

    // saturate, then, when clipping is requested, clip to the segment's output range
    always_comb begin
        if (r_big) begin
            w_sat = r_neg ? V_MIN : V_MAX;
        end else if (r_sum > SUM_MAX) begin
            w_sat = V_MAX;
        end else if (r_sum < SUM_MIN) begin
            w_sat = V_MIN;
        end else begin
            w_sat = r_sum[VAL_W-1:0];
        end
        w_lo  = (r_y0 < r_y1) ? r_y0 : r_y1;
        w_up  = (r_y0 < r_y1) ? r_y1 : r_y0;
        w_clp = w_sat;
        if (r_clip) begin
            if (w_clp > w_up) begin
                w_clp = w_up;
            end
            if (w_clp < w_lo) begin
                w_clp = w_lo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_s    <= i_sample;
            r_clip <= i_clip;
        end
        if (i_cmd.ld_x0) begin
            r_x0 <= w_rx;
            r_a  <= w_rx;
        end
        if (i_cmd.ld_x1) begin
            r_x1 <= w_rx;
        end
        if (i_cmd.shift_a) begin
            r_a <= w_rx;
        end
        if (i_cmd.ld_seg0) begin
            r_sx0 <= w_rx;
            r_y0  <= w_ry;
        end
        if (i_cmd.ld_seg1) begin
            r_y1       <= w_ry;
            r_mdx      <= f_mag(w_dx);
            r_mdy      <= f_mag(w_dy);
            r_mden     <= f_mag(w_den);
            r_neg      <= w_dx[DIFF_W-1] ^ w_dy[DIFF_W-1] ^ w_den[DIFF_W-1];
            r_den_zero <= (w_den == '0);
            r_ovf      <= 1'b0;
        end
        if (i_cmd.mul0) begin
            r_prod <= PROD_W'(w_p0);
        end
        if (i_cmd.mul1) begin
            r_pp <= w_p1;
        end
        if (i_cmd.mul2) begin
            r_prod <= r_prod + {r_pp, 16'b0};
        end
        if (i_cmd.div_init) begin
            // quotient at or above 2^41 saturates regardless of the low bits
            r_ovf <= ({8'b0, r_prod} >= {r_mden, 41'b0});
            r_rem <= r_prod;
            r_dsh <= {1'b0, r_mden, 40'b0};
            r_q   <= '0;
        end
        if (i_cmd.div_step) begin
            if (w_ge) begin
                r_rem <= r_rem - r_dsh[PROD_W-1:0];
            end
            r_q   <= {r_q[QBITS-2:0], w_ge};
            r_dsh <= r_dsh >> 1;
        end
        if (i_cmd.sum) begin
            r_big <= 1'b0;
            if (r_den_zero) begin
                r_sum <= w_y0e;
            end else if (w_qbig) begin
                r_big <= 1'b1;
            end else begin
                r_sum <= r_neg ? (w_y0e - $signed(w_qe)) : (w_y0e + $signed(w_qe));
            end
        end
        if (i_cmd.fin) begin
            r_value <= i_cmd.found ? w_clp : '0;
            r_found <= i_cmd.found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;
    assign o_found     = r_found;

endmodule

// ===== hdl/curve_linear_interpolator.sv =====
// Piecewise-linear curve mapper, signed Q16.16.
// Input channel (i_in_valid / o_in_stall): an item with i_action low writes
// knot i_knot_index (i_knot_in, i_knot_out) and gives no result;
// with i_action high it maps i_sample through the curve, optionally clipped
// to the chosen segment's output range (i_clip), and gives one result.
// Output channel (o_out_valid / i_out_stall): o_value and o_found; found low
// means a flat curve or no bracketing segment, with value 0.
// i_cfg_we writes i_cfg_data as the number of knots in use (2..MAX_KNOTS).
// An evaluation reads the first knots and the last knot, scans the knots,
// fetches the segment, does the split multiply and the restoring divide (1
// bit per cycle, 41 quotient bits), then adds, saturates and clips. The
// single read port of the knot tables and the divider serialize this work;
// one evaluation is worked at a time.
// Load items are taken every cycle while idle.
// Reset clears control and sets the knot count to 2; knots are undefined
// until written. A result waits in the output register while the receiver
// stalls; the next item can be accepted meanwhile and finishes only once
// that register is free.
module curve_linear_interpolator #(
    parameter int MAX_KNOTS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_action,
    input  logic [3:0]         i_knot_index,
    input  logic signed [31:0] i_knot_in,
    input  logic signed [31:0] i_knot_out,
    input  logic signed [31:0] i_sample,
    input  logic               i_clip,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_value,
    output logic               o_found,
    input  logic               i_cfg_we,
    input  logic [4:0]         i_cfg_data
);
    import cli_pkg::*;

    localparam int ADDR_W = $clog2(MAX_KNOTS);

    t_cmd              w_cmd;
    t_sts              w_sts;
    logic [ADDR_W-1:0] w_waddr, w_raddr;

    cli_ctrl #(.MAX_KNOTS(MAX_KNOTS)) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_action     (i_action),
        .i_knot_index (i_knot_index),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_sts        (w_sts),
        .o_cmd        (w_cmd),
        .o_waddr      (w_waddr),
        .o_raddr      (w_raddr)
    );

    cli_dp #(.MAX_KNOTS(MAX_KNOTS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_waddr     (w_waddr),
        .i_raddr     (w_raddr),
        .i_knot_in   (i_knot_in),
        .i_knot_out  (i_knot_out),
        .i_sample    (i_sample),
        .i_clip      (i_clip),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_value     (o_value),
        .o_found     (o_found)
    );

endmodule

// ===== sim/curve_linear_interpolator_tb.sv =====
`timescale 1ns / 100ps

module curve_linear_interpolator_tb;
    import cli_pkg::*;

    localparam int NKNOTS      = 16;
    localparam int SETTLE      = 120;
    localparam int STALL_LIMIT = 20000;
    localparam longint VMAX    = 64'sd2147483647;
    localparam longint VMIN    = -64'sd2147483648;

    typedef struct {
        logic signed [31:0] value;
        logic               found;
    } t_mapped;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic               i_action = 1'b0;
    logic [3:0]         i_knot_index = '0;
    logic signed [31:0] i_knot_in = '0;
    logic signed [31:0] i_knot_out = '0;
    logic signed [31:0] i_sample = '0;
    logic               i_clip = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [31:0] o_value;
    logic               o_found;
    logic               i_cfg_we = 1'b0;
    logic [4:0]         i_cfg_data = '0;

    longint   curve_x [NKNOTS];
    longint   curve_y [NKNOTS];
    logic [4:0] knot_count;
    t_mapped  pending_results[$];
    int       err_count = 0;
    int       idle_cycles = 0;
    bit       gaps_on = 1'b1;

    curve_linear_interpolator DUT (.*);

    always #10 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_mapped map_sample(logic signed [31:0] smp, logic clp);
        t_mapped m;
        longint s, x0, x1, y0, y1, dx, dy, den, r, lo, up;
        logic [63:0] mx, my, md, q;
        logic neg;
        int len, hi, dir;
        s = smp;
        len = knot_count;
        if (len < 2) len = 2;
        if (len > NKNOTS) len = NKNOTS;
        hi = 0;
        dir = 0;
        r = 0;
        if (curve_x[1] > curve_x[0]) dir = 1;
        else if (curve_x[1] < curve_x[0]) dir = -1;
        if (dir > 0) begin
            if (s < curve_x[0]) hi = 1;
            else if (s > curve_x[len-1]) hi = len - 1;
        end else if (dir < 0) begin
            if (s > curve_x[0]) hi = 1;
            else if (s < curve_x[len-1]) hi = len - 1;
        end
        if (dir != 0 && hi == 0) begin
            for (int i = 1; i < len; i++) begin
                if (dir > 0 ? (s <= curve_x[i] && s >= curve_x[i-1])
                            : (s >= curve_x[i] && s <= curve_x[i-1])) begin
                    hi = i;
                    break;
                end
            end
        end
        if (hi != 0) begin
            x0 = curve_x[hi-1]; x1 = curve_x[hi];
            y0 = curve_y[hi-1]; y1 = curve_y[hi];
            dx = s - x0; dy = y1 - y0; den = x1 - x0;
            if (den == 0) begin
                r = y0;
            end else begin
                neg = ((dx < 0) != (dy < 0)) != (den < 0);
                mx = dx < 0 ? -dx : dx;
                my = dy < 0 ? -dy : dy;
                md = den < 0 ? -den : den;
                q = (mx * my) / md;
                if (dx == 0 || dy == 0) q = 0;
                if (q > 64'd1 << 40) r = neg ? VMIN : VMAX;
                else r = y0 + (neg ? -longint'(q) : longint'(q));
            end
            if (r > VMAX) r = VMAX;
            if (r < VMIN) r = VMIN;
            if (clp) begin
                lo = y0 < y1 ? y0 : y1;
                up = y0 < y1 ? y1 : y0;
                if (r > up) r = up;
                if (r < lo) r = lo;
            end
        end
        m.value = r[31:0];
        m.found = hi != 0;
        return m;
    endfunction

    // Drive one item and hold it until the transfer happens.
    task automatic send_item(logic act, logic [3:0] idx, logic signed [31:0] kin,
                             logic signed [31:0] kout, logic signed [31:0] smp, logic clp);
        int gap;
        bit stalled;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_knot_index <= idx;
        i_knot_in    <= kin;
        i_knot_out   <= kout;
        i_sample     <= smp;
        i_clip       <= clp;
        do begin
            @(negedge i_clk);
            stalled = o_in_stall;
            @(posedge i_clk);
        end while (stalled);
        if (act == ACT_LOAD) begin
            curve_x[idx] = kin;
            curve_y[idx] = kout;
        end else begin
            pending_results.push_back(map_sample(smp, clp));
        end
    endtask

    task automatic load_knot(int idx, logic signed [31:0] kin, logic signed [31:0] kout);
        send_item(ACT_LOAD, idx[3:0], kin, kout, $urandom, 1'($urandom_range(0, 1)));
    endtask

    task automatic eval_sample(logic signed [31:0] smp, logic clp);
        send_item(ACT_EVAL, 4'($urandom_range(0, 15)), $urandom, $urandom, smp, clp);
    endtask

    // Write the knot count only once the block has drained.
    task automatic set_knot_count(logic [4:0] n);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending_results.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= n;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        knot_count = n;
    endtask

    task automatic load_curve(int kind, int shift);
        int vals[$];
        vals = {};
        for (int i = 0; i < NKNOTS; i++) vals.push_back($signed($urandom) >>> shift);
        if (kind == 0) vals.sort();
        else if (kind == 1) vals.rsort();
        for (int i = 0; i < NKNOTS; i++)
            load_knot(i, vals[i], $signed($urandom) >>> $urandom_range(0, 20));
    endtask

    task automatic test_table_load();
        for (int i = 0; i < NKNOTS; i++)
            load_knot(i, (i - 4) * 32'sh10000, (i % 3) * 32'sh28000 - 32'sh20000);
    endtask

    task automatic test_range_edges();
        set_knot_count(5'd16);
        eval_sample(32'sh8000_0000, 1'b0);
        eval_sample(32'sh7fff_ffff, 1'b0);
        eval_sample(32'sh8000_0000, 1'b1);
        eval_sample(32'sh7fff_ffff, 1'b1);
        eval_sample(-4 * 32'sh10000, 1'b0);
        eval_sample(11 * 32'sh10000, 1'b0);
        eval_sample(32'sh0000_8000, 1'b1);
        set_knot_count(5'd2);
        eval_sample(32'sh0003_0000, 1'b0);
        eval_sample(32'sh0003_0000, 1'b1);
    endtask

    task automatic test_length_clamp();
        set_knot_count(5'd0);
        eval_sample(32'sh0005_0000, 1'b0);
        set_knot_count(5'd1);
        eval_sample(-32'sh0005_0000, 1'b0);
        set_knot_count(5'd31);
        eval_sample(32'sh0020_0000, 1'b0);
        set_knot_count(5'd17);
        eval_sample(32'sh0002_4000, 1'b1);
    endtask

    task automatic test_flat_and_zero_width();
        set_knot_count(5'd6);
        load_knot(1, -4 * 32'sh10000, 32'sh0001_0000);
        eval_sample(32'sh0001_0000, 1'b0);
        load_knot(1, -3 * 32'sh10000, 32'sh0001_0000);
        load_knot(3, -2 * 32'sh10000, 32'sh0007_0000);
        eval_sample(-2 * 32'sh10000, 1'b0);
        eval_sample(-2 * 32'sh10000, 1'b1);
        // steep first segment drives the extrapolation below the first knot into saturation
        load_knot(0, 32'sh0000_0000, 32'sh8000_0000);
        load_knot(1, 32'sh0000_0001, 32'sh7fff_ffff);
        eval_sample(32'sh7fff_ffff, 1'b0);
        eval_sample(32'sh8000_0000, 1'b0);
    endtask

    task automatic test_random_curves();
        int kind, shift, k, r;
        logic signed [31:0] smp;
        for (int ph = 0; ph < 20; ph++) begin
            r = $urandom_range(0, 9);
            if (r == 0) set_knot_count(5'($urandom_range(17, 31)));
            else if (r == 1) set_knot_count(5'($urandom_range(0, 1)));
            else set_knot_count(5'($urandom_range(2, 16)));
            gaps_on = $urandom_range(0, 3) != 0;
            kind = $urandom_range(0, 9) < 8 ? $urandom_range(0, 1) : 2;
            shift = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 24);
            load_curve(kind, shift);
            for (int n = 0; n < 30; n++) begin
                r = $urandom_range(0, 99);
                k = $urandom_range(0, 15);
                if (r < 10) begin
                    load_knot(k, $signed($urandom) >>> shift, $urandom);
                    continue;
                end
                if (r < 50) smp = 32'(curve_x[k] + longint'($urandom_range(0, 64)) - 32);
                else if (r < 80) smp = $signed($urandom) >>> shift;
                else smp = $urandom;
                eval_sample(smp, 1'($urandom_range(0, 1)));
            end
        end
        gaps_on = 1'b1;
    endtask

    // Receiver stall pattern.
    always @(posedge i_clk) begin
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on) i_out_stall <= 1'b0;
        else if (r < 3) i_out_stall <= 1'b1;
        else if (r < 60) i_out_stall <= i_out_stall && r > 20;
        else i_out_stall <= 1'b0;
    end

    // Compare each result transfer with the oldest expectation.
    always begin
        bit took;
        logic signed [31:0] got_value;
        logic got_found;
        t_mapped want;
        @(negedge i_clk);
        took = o_out_valid && !i_out_stall && i_rst_n;
        got_value = o_value;
        got_found = o_found;
        if ((i_in_valid && !o_in_stall) || took) idle_cycles = 0;
        else idle_cycles++;
        @(posedge i_clk);
        if (took) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result value=%0d found=%0b", got_value, got_found);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (got_value !== want.value) begin
                    $error("value: expected %0d, got %0d", want.value, got_value);
                    err_count++;
                end
                if (got_found !== want.found) begin
                    $error("found: expected %0b, got %0b", want.found, got_found);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= STALL_LIMIT) begin
            $display("curve_linear_interpolator_tb: done, errors");
            $finish;
        end
    end

    initial begin
        knot_count = 5'd2;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_table_load();
        test_range_edges();
        test_length_clamp();
        test_flat_and_zero_width();
        test_random_curves();
        i_in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
        if (err_count == 0 && pending_results.size() == 0)
            $display("curve_linear_interpolator_tb: done, clean");
        else
            $display("curve_linear_interpolator_tb: done, errors");
        $finish;
    end

endmodule
